### rtl/ufd_pkg.sv
package ufd_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_SYNC2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN_LO  = 4'd4,
      PH_LEN_HI  = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CK_A    = 4'd7,
      PH_CK_B    = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD_END = 2'd1,
      KIND_BAD_END  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [15:0] hdr_length;
      logic [15:0] byte_index;
      logic [7:0]  payload_byte;
      logic [7:0]  msg_id;
      logic [7:0]  msg_class;
   } rsp_data_type;

   typedef struct packed {
      kind_type     kind;
      logic         last;
      rsp_data_type data;
   } rsp_item_type;

endpackage

### rtl/ubx_frame_deframer_unit.sv
// Frame parser for a binary receiver protocol: request bytes come in one per cycle, the
// unit hunts for the sync pair 0xB5 0x62, reads class, id and a little-endian payload
// length, and runs an 8-bit Fletcher sum over class through payload. Every payload byte
// leaves as a response with kind 0; after the two checksum bytes one closing response
// (tlast high) has kind 1 for a good frame or kind 2 for a bad one. A bad frame is consumed
// whole. The frame state machine updates on every accepted byte, and a two-entry output
// register (main stage plus skid stage) lets the unit keep taking bytes while one response
// waits; req_tready drops only while both entries are full.
module ubx_frame_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // msg_class[7:0], msg_id[15:8], payload_byte[23:16], byte_index[39:24],
   // hdr_length[55:40]
   output logic [55:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast
);
   import ufd_pkg::*;

   phase_type    phase_ff, phase_in;
   logic [7:0]   class_ff, class_in;
   logic [7:0]   id_ff, id_in;
   logic [15:0]  length_ff, length_in;
   logic [15:0]  count_ff, count_in;
   logic [7:0]   sum_a_ff, sum_a_in;
   logic [7:0]   sum_b_ff, sum_b_in;
   logic [7:0]   ck_a_ff, ck_a_in;

   rsp_item_type out_ff, out_in;
   rsp_item_type skid_ff, skid_in;
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;

   rsp_item_type res;
   logic         res_valid;
   logic         accept;
   logic         pop;
   logic [7:0]   acc_a;
   logic [7:0]   acc_b;
   logic [15:0]  count_next;
   logic [15:0]  length_hi;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   // Fletcher step on the incoming byte; the class byte starts from zero sums.
   assign acc_a      = ((phase_ff == PH_CLASS) ? 8'd0 : sum_a_ff) + req_tdata;
   assign acc_b      = ((phase_ff == PH_CLASS) ? 8'd0 : sum_b_ff) + acc_a;
   assign count_next = count_ff + 16'd1;
   assign length_hi  = {req_tdata, length_ff[7:0]};

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SYNC2: begin
               if (req_tdata == SYNC_SECOND) phase_in = PH_CLASS;
               else if (req_tdata == SYNC_FIRST) phase_in = PH_SYNC2;
               else phase_in = PH_HUNT;
            end
            PH_CLASS:   phase_in = PH_ID;
            PH_ID:      phase_in = PH_LEN_LO;
            PH_LEN_LO:  phase_in = PH_LEN_HI;
            PH_LEN_HI:  phase_in = (length_hi == 16'd0) ? PH_CK_A : PH_PAYLOAD;
            PH_PAYLOAD: phase_in = (count_next >= length_ff) ? PH_CK_A : PH_PAYLOAD;
            PH_CK_A:    phase_in = PH_CK_B;
            PH_CK_B:    phase_in = PH_HUNT;
            default:    phase_in = (req_tdata == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
         endcase
      end
   end

   // Frame fields, sums and the response for this byte.
   always_comb begin
      class_in  = class_ff;
      id_in     = id_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_a_in  = sum_a_ff;
      sum_b_in  = sum_b_ff;
      ck_a_in   = ck_a_ff;
      res_valid = 1'b0;
      res.kind                = KIND_PAYLOAD;
      res.last                = 1'b0;
      res.data.msg_class      = class_ff;
      res.data.msg_id         = id_ff;
      res.data.payload_byte   = 8'd0;
      res.data.byte_index     = 16'd0;
      res.data.hdr_length     = length_ff;
      if (accept) begin
         unique case (phase_ff) inside
            PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD: begin
               sum_a_in = acc_a;
               sum_b_in = acc_b;
            end
            default: ;
         endcase
         unique case (phase_ff)
            PH_CLASS:  class_in = req_tdata;
            PH_ID:     id_in = req_tdata;
            PH_LEN_LO: length_in = {8'd0, req_tdata};
            PH_LEN_HI: begin
               length_in = length_hi;
               count_in  = 16'd0;
            end
            PH_PAYLOAD: begin
               res_valid             = 1'b1;
               res.data.payload_byte = req_tdata;
               res.data.byte_index   = count_ff;
               count_in              = count_next;
            end
            PH_CK_A: ck_a_in = req_tdata;
            PH_CK_B: begin
               res_valid = 1'b1;
               res.last  = 1'b1;
               res.kind  = ((ck_a_ff == sum_a_ff) && (req_tdata == sum_b_ff)) ?
                           KIND_GOOD_END : KIND_BAD_END;
            end
            default: ;
         endcase
      end
   end

   // Output register with a skid stage behind it.
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!out_valid_ff || pop) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         class_ff      <= 8'd0;
         id_ff         <= 8'd0;
         length_ff     <= 16'd0;
         count_ff      <= 16'd0;
         sum_a_ff      <= 8'd0;
         sum_b_ff      <= 8'd0;
         ck_a_ff       <= 8'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         class_ff      <= class_in;
         id_ff         <= id_in;
         length_ff     <= length_in;
         count_ff      <= count_in;
         sum_a_ff      <= sum_a_in;
         sum_b_ff      <= sum_b_in;
         ck_a_ff       <= ck_a_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.data;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a response while the output stage is empty");

   a_last_matches_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser != KIND_PAYLOAD)))
      else $error("tlast disagrees with the response kind");

   a_end_gives_response : assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == PH_CK_B)) |=> rsp_tvalid)
      else $error("second checksum byte produced no frame end response");

   a_hunt_after_end : assert property (@(posedge clock) disable iff (reset)
      (accept && (phase_ff == PH_CK_B)) |=> (phase_ff == PH_HUNT))
      else $error("parser did not return to hunting after a frame");

endmodule

### tb/ubx_frame_checker.sv
module ubx_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // msg_class[7:0], msg_id[15:8], payload_byte[23:16], byte_index[39:24],
   // hdr_length[55:40]
   input  logic [55:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,   // kind[1:0]
   input  logic        rsp_tlast,
   output int          errors,
   output int          pending,
   output int          checked
);
   import ufd_pkg::*;

   localparam int PRINT_LIMIT = 40;

   phase_type    phase;
   logic [7:0]   frame_class;
   logic [7:0]   frame_id;
   logic [15:0]  frame_length;
   logic [15:0]  payload_count;
   logic [7:0]   sum_a;
   logic [7:0]   sum_b;
   logic [7:0]   ck_a_seen;
   rsp_item_type expected_q[$];
   int           error_total;
   int           checked_total;

   task automatic report(input string msg);
      if (error_total < PRINT_LIMIT) begin
         $display("%0t ubx_frame_checker: %s", $time, msg);
      end
      error_total++;
   endtask

   task automatic add_to_sums(input logic [7:0] b);
      sum_a = sum_a + b;
      sum_b = sum_b + sum_a;
   endtask

   task automatic queue_result(input kind_type kind, input logic [7:0] pbyte,
                               input logic [15:0] index, input logic lastflag);
      rsp_item_type item;
      item.kind                = kind;
      item.last                = lastflag;
      item.data.msg_class      = frame_class;
      item.data.msg_id         = frame_id;
      item.data.payload_byte   = pbyte;
      item.data.byte_index     = index;
      item.data.hdr_length     = frame_length;
      expected_q.push_back(item);
   endtask

   // Advances the frame tracker by one accepted request byte.
   task automatic take_byte(input logic [7:0] b);
      case (phase)
         PH_SYNC2: begin
            if (b == SYNC_SECOND) begin
               phase = PH_CLASS;
            end else if (b == SYNC_FIRST) begin
               phase = PH_SYNC2;
            end else begin
               phase = PH_HUNT;
            end
         end
         PH_CLASS: begin
            frame_class = b;
            sum_a = '0;
            sum_b = '0;
            add_to_sums(b);
            phase = PH_ID;
         end
         PH_ID: begin
            frame_id = b;
            add_to_sums(b);
            phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            frame_length = {8'h00, b};
            add_to_sums(b);
            phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            frame_length[15:8] = b;
            add_to_sums(b);
            payload_count = '0;
            phase = (frame_length == 16'd0) ? PH_CK_A : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            add_to_sums(b);
            queue_result(KIND_PAYLOAD, b, payload_count, 1'b0);
            payload_count = payload_count + 16'd1;
            if (payload_count >= frame_length) begin
               phase = PH_CK_A;
            end
         end
         PH_CK_A: begin
            ck_a_seen = b;
            phase = PH_CK_B;
         end
         PH_CK_B: begin
            if ((ck_a_seen == sum_a) && (b == sum_b)) begin
               queue_result(KIND_GOOD_END, 8'h00, 16'h0000, 1'b1);
            end else begin
               queue_result(KIND_BAD_END, 8'h00, 16'h0000, 1'b1);
            end
            phase = PH_HUNT;
         end
         default: begin
            phase = (b == SYNC_FIRST) ? PH_SYNC2 : PH_HUNT;
         end
      endcase
   endtask

   task automatic compare_response();
      rsp_item_type want;
      rsp_data_type got;
      got = rsp_tdata;
      if (expected_q.size() == 0) begin
         report($sformatf("response kind %0d arrived with none expected", rsp_tuser));
         return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      if (rsp_tuser !== want.kind)
         report($sformatf("kind %0d, expected %0d", rsp_tuser, want.kind));
      if (rsp_tlast !== want.last)
         report($sformatf("last %0b, expected %0b", rsp_tlast, want.last));
      if (got.msg_class !== want.data.msg_class)
         report($sformatf("msg_class %0h, expected %0h", got.msg_class, want.data.msg_class));
      if (got.msg_id !== want.data.msg_id)
         report($sformatf("msg_id %0h, expected %0h", got.msg_id, want.data.msg_id));
      if (got.payload_byte !== want.data.payload_byte)
         report($sformatf("payload_byte %0h, expected %0h",
                          got.payload_byte, want.data.payload_byte));
      if (got.byte_index !== want.data.byte_index)
         report($sformatf("byte_index %0d, expected %0d",
                          got.byte_index, want.data.byte_index));
      if (got.hdr_length !== want.data.hdr_length)
         report($sformatf("hdr_length %0d, expected %0d",
                          got.hdr_length, want.data.hdr_length));
      checked_total++;
   endtask

   // Responses are compared before the request of the same edge is tracked, since the
   // unit registers its output and cannot answer a request in the cycle it takes it.
   always @(posedge clock) begin
      if (reset) begin
         phase         = PH_HUNT;
         frame_class   = '0;
         frame_id      = '0;
         frame_length  = '0;
         payload_count = '0;
         sum_a         = '0;
         sum_b         = '0;
         ck_a_seen     = '0;
         expected_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            compare_response();
         end
         if (req_tvalid && req_tready) begin
            take_byte(req_tdata);
         end
      end
      errors  <= error_total;
      pending <= expected_q.size();
      checked <= checked_total;
   end

endmodule

### tb/tb_ubx_frame_deframer_unit.sv
module tb_ubx_frame_deframer_unit;

   import ufd_pkg::*;

   localparam int BYTE_TARGET  = 1150;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int   errors;
   int   pending;
   int   checked;
   int   idle_cycles  = 0;
   int   frame_bytes  = 0;
   int   frames_sent  = 0;
   int   frames_bad   = 0;
   int   noise_bytes  = 0;
   logic steady_send  = 1'b0;

   ubx_frame_deframer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   ubx_frame_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .errors     (errors),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Ends the run if no request or response moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_ubx_frame_deframer_unit: errors");
         $finish;
      end
   end

   // Receiver side: long stretches that are always ready alternate with stretches of
   // short stalls and an occasional long one.
   initial begin
      int   stall;
      int   stretch;
      logic relaxed;
      stall   = 0;
      stretch = 0;
      relaxed = 1'b0;
      forever begin
         @(posedge clock);
         if (stretch == 0) begin
            relaxed = ($urandom_range(0, 3) == 0);
            stretch = $urandom_range(50, 300);
         end else begin
            stretch--;
         end
         if (stall > 0) begin
            stall--;
         end else if (!relaxed && $urandom_range(0, 3) == 0) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
         end
         rsp_tready <= (stall == 0);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_send || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Called at a rising edge; returns at the edge where the request is taken.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                             input logic [15:0] len, input logic corrupt);
      logic [7:0] hdr [4];
      logic [7:0] ck_a;
      logic [7:0] ck_b;
      logic [7:0] b;
      int         i;
      hdr  = '{cls, id, len[7:0], len[15:8]};
      ck_a = '0;
      ck_b = '0;
      send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      for (i = 0; i < 4; i++) begin
         ck_a = ck_a + hdr[i];
         ck_b = ck_b + ck_a;
         send_byte(hdr[i]);
      end
      for (i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         ck_a = ck_a + b;
         ck_b = ck_b + ck_a;
         send_byte(b);
      end
      if (corrupt) begin
         // Break A, B or both by a nonzero flip.
         case ($urandom_range(0, 2))
            0: ck_a = ck_a ^ 8'($urandom_range(1, 255));
            1: ck_b = ck_b ^ 8'($urandom_range(1, 255));
            default: begin
               ck_a = ck_a ^ 8'($urandom_range(1, 255));
               ck_b = ck_b ^ 8'($urandom_range(1, 255));
            end
         endcase
         frames_bad++;
      end
      send_byte(ck_a);
      send_byte(ck_b);
      frames_sent++;
      frame_bytes += 8 + len;
   endtask

   // Bytes between frames; a second sync byte never appears here.
   task automatic send_noise(input int n);
      logic [7:0] b;
      repeat (n) begin
         b = ($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom_range(0, 255));
         if (b == SYNC_SECOND) b = ~b;
         send_byte(b);
         noise_bytes++;
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int         r;
      int         len;
      logic [7:0] b;
      logic       paused;
      paused = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Stray bytes, a wrong second sync byte, then a repeated first sync byte ahead of a
      // zero-length good frame and a one-byte frame with a bad checksum.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(SYNC_FIRST);
      send_byte(8'h00);
      send_byte(SYNC_FIRST);
      send_frame(8'hFF, 8'h00, 16'd0, 1'b0);
      send_frame(8'h00, 8'hFF, 16'd1, 1'b1);
      wait_drained();

      while (frame_bytes < BYTE_TARGET) begin
         steady_send = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 12) begin
            send_noise($urandom_range(1, 6));
         end else if (r < 20) begin
            send_byte(SYNC_FIRST);
            noise_bytes++;
            if ($urandom_range(0, 1) == 0) begin
               send_byte(SYNC_FIRST);
            end else begin
               b = 8'($urandom_range(0, 255));
               if (b == SYNC_SECOND || b == SYNC_FIRST) b = 8'h00;
               send_byte(b);
            end
            noise_bytes++;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               len = 0;
            end else if (r < 80) begin
               len = $urandom_range(1, 8);
            end else begin
               len = $urandom_range(9, 40);
            end
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len),
                       $urandom_range(0, 9) == 0);
         end
         if (!paused && frame_bytes > BYTE_TARGET / 2) begin
            // Let the unit empty out, then send one frame with a payload past 255 bytes.
            wait_drained();
            paused = 1'b1;
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       16'(256 + $urandom_range(0, 40)), 1'b0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d frames (%0d with a broken checksum, one longer than 255 bytes)",
               frames_sent, frames_bad);
      $display("plus %0d stray and sync-error bytes; %0d responses compared.",
               noise_bytes, checked);
      if (errors == 0) begin
         $display("tb_ubx_frame_deframer_unit: clean");
      end else begin
         $display("tb_ubx_frame_deframer_unit: errors");
      end
      $finish;
   end

endmodule
